FILE: rtl/indexed_min_heap_decrease_key_macros.svh
// Assertion macros for the indexed min-heap block.
// Used by the core; there are no other dependencies.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH
`ifndef SYNTHESIS
// Condition that holds at every clock edge outside reset.
`define IMHDK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define IMHDK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IMHDK_ASSERT(lbl, clk, rst, prop, msg)
`define IMHDK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/imhdk_pkg.sv
// Shared types, codes and constants of the indexed min-heap block.
// No dependencies.
`default_nettype none
package imhdk_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int ITEM_W = 10;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int FUNC_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECREASE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_GONE  = 2'd2;

  localparam logic REG_ITEMS_IN_USE = 1'b0;
  localparam logic REG_START_KEY    = 1'b1;

  localparam logic [CNT_W-1:0] ITEMS_RESET     = 11'd1024;
  localparam logic [KEY_W-1:0] START_KEY_RESET = 32'd10000;

  typedef struct packed {
    logic [CNT_W-1:0] items_in_use;
    logic [KEY_W-1:0] start_key;
  } cfg_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  key;
    logic              applied;
    logic [CNT_W-1:0]  remaining;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_DK_POS,
    ST_DK_KEY,
    ST_SD_L,
    ST_SD_R,
    ST_SD_C,
    ST_SU_P,
    ST_SU_C,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key, top level.
// Depends on imhdk_pkg, imhdk_cfg, imhdk_core (and imhdk_ram below it).
//
//  - Input channel (in_valid/in_stall, func/item/new_key) takes one command:
//    restart, extract minimum or decrease key; each one returns one result
//    item on the output channel (out_valid/out_stall).
//  - One command at a time: in_stall stays high until the result is loaded
//    into the output register, then drops while the block is idle.
//  - Restart sweeps all CAPACITY entries, then, for a valid source item,
//    sifts it down. A level down takes left, right and compare steps, a
//    level up parent and compare steps, over one RAM read port.
//  - Empty extracts, unknown codes, out-of-range decreases and decreases
//    before any restart go straight to the result; decreases of removed
//    items stop after the position lookup.
//  - Reset empties the heap and clears the primed flag, so every item reads
//    as removed; the RAMs are not cleared, since only entries written by a
//    restart are ever read.
//  - A stalled result waits in the output register while the block takes the
//    next command; hold the next result until the slot frees.
`default_nettype none
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY = imhdk_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [imhdk_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [imhdk_pkg::DATA_W-1:0]      pwdata,
  output logic      [imhdk_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [imhdk_pkg::FUNC_W-1:0]      func,
  input  wire logic [imhdk_pkg::ITEM_W-1:0]      item,
  input  wire logic [imhdk_pkg::KEY_W-1:0]       new_key,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [imhdk_pkg::ITEM_W-1:0]      out_item,
  output logic      [imhdk_pkg::KEY_W-1:0]       out_key,
  output logic                                   applied,
  output logic      [imhdk_pkg::CNT_W-1:0]       remaining,
  output logic      [imhdk_pkg::STAT_W-1:0]      status
);

  imhdk_pkg::cfg_t cfg;
  imhdk_pkg::res_t res;
  logic            res_valid;
  logic            res_ready;
  logic            load;

  imhdk_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imhdk_core #(.CAPACITY(CAPACITY)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .item      (item),
    .new_key   (new_key),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output slot is free when empty or being taken this cycle
  assign res_ready = !out_valid || !out_stall;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload while stalled, advance on load
  always_ff @(posedge clk) begin
    if (load) begin
      out_item  <= res.item;
      out_key   <= res.key;
      applied   <= res.applied;
      remaining <= res.remaining;
      status    <= res.status;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/imhdk_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/imhdk_cfg.sv
// APB-style register block: items_in_use and start_key.
// Depends on imhdk_pkg.
`default_nettype none
module imhdk_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [imhdk_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [imhdk_pkg::DATA_W-1:0]        pwdata,
  output logic      [imhdk_pkg::DATA_W-1:0]        prdata,
  output logic                                     pready,
  output imhdk_pkg::cfg_t                          cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // word index sits in bit 2; the low byte-lane bits alias
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.items_in_use <= imhdk_pkg::ITEMS_RESET;
      cfg.start_key    <= imhdk_pkg::START_KEY_RESET;
    end else if (wr) begin
      if (paddr[2] == imhdk_pkg::REG_ITEMS_IN_USE) begin
        cfg.items_in_use <= pwdata[imhdk_pkg::CNT_W-1:0];
      end else begin
        cfg.start_key <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == imhdk_pkg::REG_START_KEY) begin
      prdata = cfg.start_key;
    end else begin
      prdata = imhdk_pkg::DATA_W'(cfg.items_in_use);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/imhdk_core.sv
// Heap sequencer: heap store (key, item) and item map (removed, position)
// in two RAMs, with restart sweep, extract, decrease and sift walks.
// Depends on imhdk_pkg, imhdk_ram and the assertion macro header.
`default_nettype none
`include "indexed_min_heap_decrease_key_macros.svh"
module imhdk_core #(
  parameter int CAPACITY = imhdk_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [imhdk_pkg::FUNC_W-1:0]     func,
  input  wire logic [imhdk_pkg::ITEM_W-1:0]     item,
  input  wire logic [imhdk_pkg::KEY_W-1:0]      new_key,
  input  wire imhdk_pkg::cfg_t                  cfg,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output imhdk_pkg::res_t                       res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int KW = imhdk_pkg::KEY_W;
  localparam int IW = imhdk_pkg::ITEM_W;
  localparam int HW = KW + AW;
  localparam int PW = AW + 1;
  localparam int WW = (LW > IW) ? LW : IW;

  imhdk_pkg::state_t state, state_next;

  logic [LW-1:0] len;
  logic          primed;
  logic [IW-1:0] item_r;
  logic [KW-1:0] nk_r;
  logic [LW-1:0] n_r;
  logic          src_ok;
  logic [AW-1:0] j;
  logic [AW-1:0] p;
  logic [KW-1:0] v_key;
  logic [AW-1:0] v_item;
  logic [KW-1:0] lft_key;
  logic [AW-1:0] lft_item;
  logic [IW-1:0] r_item;
  logic [KW-1:0] r_key;
  logic          r_app;
  logic [imhdk_pkg::STAT_W-1:0] r_stat;

  logic          heap_we, pos_we;
  logic [AW-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
  logic [HW-1:0] heap_wdata, heap_rdata;
  logic [PW-1:0] pos_wdata, pos_rdata;

  logic [KW-1:0] rd_key;
  logic [AW-1:0] rd_item;
  logic          pos_rem;
  logic [AW-1:0] pos_p;
  logic          dk_gone;
  logic [LW-1:0] n_clamp;
  logic          item_big;
  logic          in_src_ok;
  logic [XW-1:0] l_idx, r_idx, len_x;
  logic          l_ok, r_ok;
  logic [AW-1:0] parent;
  logic          sel_l, sel_r, sd_promote, su_promote;
  logic [KW-1:0] best_key, c_key;
  logic [AW-1:0] c_item, c_idx;
  logic          fill_hit, fill_root, fill_rem, fill_last;
  logic [AW-1:0] fill_item, fill_pos;

  imhdk_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhdk_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign rd_key  = heap_rdata[HW-1:AW];
  assign rd_item = heap_rdata[AW-1:0];
  assign pos_rem = pos_rdata[AW];
  assign pos_p   = pos_rdata[AW-1:0];
  assign dk_gone = pos_rem || (LW'(pos_p) >= len);

  assign n_clamp   = (32'(cfg.items_in_use) > 32'(CAPACITY)) ? LW'(CAPACITY)
                                                              : LW'(cfg.items_in_use);
  assign item_big  = 32'(item) >= 32'(CAPACITY);
  assign in_src_ok = WW'(item) < WW'(n_clamp);

  assign l_idx  = XW'({p, 1'b1});
  assign r_idx  = XW'({p, 1'b0}) + XW'(2);
  assign len_x  = XW'(len);
  assign l_ok   = l_idx < len_x;
  assign r_ok   = r_idx < len_x;
  assign parent = (p - AW'(1)) >> 1;

  // left child wins ties; the right one must be strictly smaller than the best
  assign sel_l      = lft_key < v_key;
  assign best_key   = sel_l ? lft_key : v_key;
  assign sel_r      = r_ok && (rd_key < best_key);
  assign sd_promote = sel_l || sel_r;
  assign c_key      = sel_r ? rd_key : lft_key;
  assign c_item     = sel_r ? rd_item : lft_item;
  assign c_idx      = sel_r ? AW'(r_idx) : AW'(l_idx);
  assign su_promote = v_key < rd_key;

  // restart sweep: the source swaps with the root, the root entry is sifted later
  assign fill_hit  = src_ok && (WW'(j) == WW'(item_r));
  assign fill_root = src_ok && (j == '0);
  assign fill_item = fill_hit ? '0 : j;
  assign fill_pos  = fill_hit ? '0 : (fill_root ? AW'(item_r) : j);
  assign fill_rem  = LW'(j) >= n_r;
  assign fill_last = j == AW'(CAPACITY - 1);

  always_comb begin
    state_next = state;
    case (state)
      imhdk_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (func)
            imhdk_pkg::FUNC_RESTART:  state_next = imhdk_pkg::ST_FILL;
            imhdk_pkg::FUNC_EXTRACT:  state_next = (len == '0) ? imhdk_pkg::ST_DONE
                                                               : imhdk_pkg::ST_EX_ROOT;
            imhdk_pkg::FUNC_DECREASE: state_next = (!primed || item_big) ? imhdk_pkg::ST_DONE
                                                                         : imhdk_pkg::ST_DK_POS;
            default:                  state_next = imhdk_pkg::ST_DONE;
          endcase
        end
      end
      imhdk_pkg::ST_FILL: begin
        if (fill_last) begin
          state_next = src_ok ? imhdk_pkg::ST_SD_L : imhdk_pkg::ST_DONE;
        end
      end
      imhdk_pkg::ST_EX_ROOT: state_next = imhdk_pkg::ST_EX_LAST;
      imhdk_pkg::ST_EX_LAST: state_next = (len == '0) ? imhdk_pkg::ST_DONE : imhdk_pkg::ST_SD_L;
      imhdk_pkg::ST_DK_POS:  state_next = dk_gone ? imhdk_pkg::ST_DONE : imhdk_pkg::ST_DK_KEY;
      imhdk_pkg::ST_DK_KEY:  state_next = (nk_r < rd_key) ? imhdk_pkg::ST_SU_P
                                                           : imhdk_pkg::ST_DONE;
      imhdk_pkg::ST_SD_L:    state_next = l_ok ? imhdk_pkg::ST_SD_R : imhdk_pkg::ST_DONE;
      imhdk_pkg::ST_SD_R:    state_next = imhdk_pkg::ST_SD_C;
      imhdk_pkg::ST_SD_C:    state_next = sd_promote ? imhdk_pkg::ST_SD_L : imhdk_pkg::ST_DONE;
      imhdk_pkg::ST_SU_P:    state_next = (p == '0) ? imhdk_pkg::ST_DONE : imhdk_pkg::ST_SU_C;
      imhdk_pkg::ST_SU_C:    state_next = su_promote ? imhdk_pkg::ST_SU_P : imhdk_pkg::ST_DONE;
      imhdk_pkg::ST_DONE:    state_next = res_ready ? imhdk_pkg::ST_IDLE : imhdk_pkg::ST_DONE;
      default:               state_next = imhdk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = state != imhdk_pkg::ST_IDLE;
    res_valid  = state == imhdk_pkg::ST_DONE;
    heap_we    = 1'b0;
    heap_waddr = p;
    heap_wdata = {v_key, v_item};
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = v_item;
    pos_wdata  = {1'b0, p};
    pos_raddr  = AW'(item);
    case (state)
      imhdk_pkg::ST_FILL: begin
        heap_we    = 1'b1;
        heap_waddr = j;
        heap_wdata = {cfg.start_key, fill_item};
        pos_we     = 1'b1;
        pos_waddr  = j;
        pos_wdata  = {fill_rem, fill_pos};
      end
      imhdk_pkg::ST_EX_ROOT: begin
        heap_raddr = AW'(len - 1'b1);
        pos_we     = 1'b1;
        pos_waddr  = rd_item;
        pos_wdata  = {1'b1, AW'(0)};
      end
      imhdk_pkg::ST_DK_POS: begin
        heap_raddr = pos_p;
      end
      imhdk_pkg::ST_SD_L: begin
        heap_raddr = AW'(l_idx);
        if (!l_ok) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      imhdk_pkg::ST_SD_R: begin
        heap_raddr = AW'(r_idx);
      end
      imhdk_pkg::ST_SD_C: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (sd_promote) begin
          heap_wdata = {c_key, c_item};
          pos_waddr  = c_item;
        end
      end
      imhdk_pkg::ST_SU_P: begin
        heap_raddr = parent;
        if (p == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      imhdk_pkg::ST_SU_C: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (su_promote) begin
          heap_wdata = heap_rdata;
          pos_waddr  = rd_item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= imhdk_pkg::ST_IDLE;
      len    <= '0;
      primed <= 1'b0;
    end else begin
      state <= state_next;
      if (state == imhdk_pkg::ST_FILL && fill_last) begin
        len    <= n_r;
        primed <= 1'b1;
      end
      if (state == imhdk_pkg::ST_EX_ROOT) begin
        len <= len - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      imhdk_pkg::ST_IDLE: begin
        item_r <= item;
        nk_r   <= new_key;
        n_r    <= n_clamp;
        src_ok <= in_src_ok;
        j      <= '0;
        r_item <= '0;
        r_key  <= '0;
        r_app  <= 1'b0;
        r_stat <= imhdk_pkg::STAT_OK;
        case (func)
          imhdk_pkg::FUNC_RESTART: begin
            r_item <= item;
            r_key  <= in_src_ok ? new_key : '0;
            r_stat <= in_src_ok ? imhdk_pkg::STAT_OK : imhdk_pkg::STAT_GONE;
          end
          imhdk_pkg::FUNC_EXTRACT: begin
            if (len == '0) begin
              r_stat <= imhdk_pkg::STAT_EMPTY;
            end
          end
          imhdk_pkg::FUNC_DECREASE: begin
            r_item <= item;
            if (!primed || item_big) begin
              r_stat <= imhdk_pkg::STAT_GONE;
            end
          end
          default: begin
          end
        endcase
      end
      imhdk_pkg::ST_FILL: begin
        j <= j + 1'b1;
        if (fill_last) begin
          v_key  <= nk_r;
          v_item <= AW'(item_r);
          p      <= '0;
        end
      end
      imhdk_pkg::ST_EX_ROOT: begin
        r_item <= IW'(rd_item);
        r_key  <= rd_key;
        r_app  <= 1'b1;
      end
      imhdk_pkg::ST_EX_LAST: begin
        v_key  <= rd_key;
        v_item <= rd_item;
        p      <= '0;
      end
      imhdk_pkg::ST_DK_POS: begin
        p <= pos_p;
        if (dk_gone) begin
          r_stat <= imhdk_pkg::STAT_GONE;
        end
      end
      imhdk_pkg::ST_DK_KEY: begin
        if (nk_r < rd_key) begin
          v_key  <= nk_r;
          v_item <= AW'(item_r);
          r_app  <= 1'b1;
          r_key  <= nk_r;
        end else begin
          r_key <= rd_key;
        end
      end
      imhdk_pkg::ST_SD_R: begin
        lft_key  <= rd_key;
        lft_item <= rd_item;
      end
      imhdk_pkg::ST_SD_C: begin
        if (sd_promote) begin
          p <= c_idx;
        end
      end
      imhdk_pkg::ST_SU_C: begin
        if (su_promote) begin
          p <= parent;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.item      = r_item;
  assign res.key       = r_key;
  assign res.applied   = r_app;
  assign res.remaining = imhdk_pkg::CNT_W'(len);
  assign res.status    = r_stat;

  `IMHDK_ASSERT(a_len_cap, clk, rst, 32'(len) <= 32'(CAPACITY), "heap length above capacity")
  `IMHDK_ASSERT_NEXT(a_fill_len, clk, rst, state == imhdk_pkg::ST_FILL && fill_last,
    len == n_r && primed, "restart left wrong heap length")
  `IMHDK_ASSERT_NEXT(a_extract_len, clk, rst, state == imhdk_pkg::ST_EX_ROOT,
    len == LW'($past(len) - 1'b1), "extract did not shrink the heap by one")
  `IMHDK_ASSERT_NEXT(a_sd_deeper, clk, rst, state == imhdk_pkg::ST_SD_C && sd_promote,
    p > $past(p), "sift-down hole did not move down")
  `IMHDK_ASSERT_NEXT(a_su_higher, clk, rst, state == imhdk_pkg::ST_SU_C && su_promote,
    p < $past(p), "sift-up hole did not move up")

endmodule
`default_nettype wire
